// File: sv/fcs_pkg.sv
package fcs_pkg;

  // Queue and field sizing.
  localparam int unsigned QueueDepth   = 16;
  localparam int unsigned AmountBits   = 16;
  localparam int unsigned ResultLimit  = 16;
  localparam int unsigned AmountW      = 16;
  localparam int unsigned ClientW      = 4;
  localparam int unsigned CountW       = 32;
  localparam int unsigned KindW        = 3;
  localparam int unsigned IdxW         = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned TotalW       = $clog2(QueueDepth + 1);
  localparam int unsigned PopW         = $clog2(ResultLimit + 1);
  localparam int unsigned AddrW        = 3;

  // Mask that keeps the low AmountBits of an amount.
  localparam logic [AmountW-1:0] AmountMask =
    AmountW'((33'(1) << AmountBits) - 33'(1));

  // Operation codes.
  localparam logic OpWait   = 1'b0;
  localparam logic OpSignal = 1'b1;

  // Result kinds.
  localparam logic [KindW-1:0] KindGranted   = 3'd0;
  localparam logic [KindW-1:0] KindQueued    = 3'd1;
  localparam logic [KindW-1:0] KindReleased  = 3'd2;
  localparam logic [KindW-1:0] KindNoRelease = 3'd3;
  localparam logic [KindW-1:0] KindRejected  = 3'd4;

  // Register word index of initial_count.
  localparam logic RegInitialCount = 1'b0;

  typedef struct packed {
    logic               operation;
    logic [ClientW-1:0] requester;
    logic [AmountW-1:0] amount;
  } in_item_t;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [ClientW-1:0] client;
    logic [AmountW-1:0] units;
    logic [CountW-1:0]  available;
    logic               last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic reject;
    logic wait_grant;
    logic wait_queue;
    logic signal_add;
    logic pop;
    logic flush_pend;
    logic no_release;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_signal;
    logic amt_zero;
    logic fits;
    logic queue_full;
    logic head_fits;
    logic pend_valid;
    logic out_free;
  } status_t;

  // Advance a queue slot index with wrap-around.
  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] idx);
    logic [IdxW-1:0] res;
    if (idx == IdxW'(QueueDepth - 1)) begin
      res = '0;
    end else begin
      res = idx + IdxW'(1);
    end
    return res;
  endfunction

endpackage

// File: sv/fifo_counting_semaphore.sv
// Latency: a wait or rejected transaction has its result in the output register in the cycle
// after acceptance; a signal first adds its units, then releases waiters in its release phase.
// Throughput: one wait per cycle while the output is free; a signal holds the input until its
// release phase ends, with released waiters popped one per cycle from the queue head unless stalled.
// Reset: free count and initial count are zero and the queue is empty; the waiter
// storage itself is not cleared.
module fifo_counting_semaphore (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  fcs_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fcs_pkg::out_item_t          out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fcs_pkg::AddrW-1:0]   paddr,
  input  logic [fcs_pkg::CountW-1:0]  pwdata,
  output logic [fcs_pkg::CountW-1:0]  prdata,
  output logic                        pready
);
  import fcs_pkg::*;

  cmd_t              cmd;
  status_t           status;
  logic              cfg_we;
  logic              reg_hit;
  logic [CountW-1:0] cfg_rdata;

  // Register decode: one word at byte address zero.
  assign reg_hit = (paddr[AddrW-1] == RegInitialCount);
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? cfg_rdata : '0;

  fcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fcs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (in_data_i),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (pwdata),
    .cfg_rdata_o (cfg_rdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: sv/fcs_datapath.sv
module fcs_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fcs_pkg::in_item_t           item_i,
  input  logic                        cfg_we_i,
  input  logic [fcs_pkg::CountW-1:0]  cfg_wdata_i,
  output logic [fcs_pkg::CountW-1:0]  cfg_rdata_o,
  input  fcs_pkg::cmd_t               cmd_i,
  output fcs_pkg::status_t            status_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fcs_pkg::out_item_t          out_data_o
);
  import fcs_pkg::*;

  logic [CountW-1:0]  init_q;
  logic [CountW-1:0]  free_q, free_d;
  logic [AmountW-1:0] sig_amt_q;
  logic [ClientW-1:0] q_client [QueueDepth];
  logic [AmountW-1:0] q_amount [QueueDepth];
  logic [AmountW-1:0] head_amt_q;
  logic [ClientW-1:0] head_client_q;
  logic [IdxW-1:0]    head_q, head_d;
  logic [IdxW-1:0]    tail_q, tail_d;
  logic [TotalW-1:0]  total_q, total_d;
  logic [PopW-1:0]    pops_q, pops_d;
  out_item_t          pend_q, pend_d;
  logic               pend_valid_q, pend_valid_d;
  out_item_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic [AmountW-1:0] amt;
  logic [AmountW-1:0] head_amt;
  logic [ClientW-1:0] head_client;
  logic [CountW:0]    sum;
  logic [CountW-1:0]  sat_sum;
  logic [CountW-1:0]  free_minus_amt;
  logic [CountW-1:0]  free_minus_head;
  logic               out_free;
  logic               out_load;

  // Operand preparation and the shared arithmetic.
  assign amt             = item_i.amount & AmountMask;
  assign head_amt        = head_amt_q;
  assign head_client     = head_client_q;
  assign sum             = {1'b0, free_q} + (CountW + 1)'(amt);
  assign sat_sum         = sum[CountW] ? '1 : sum[CountW-1:0];
  assign free_minus_amt  = free_q - CountW'(amt);
  assign free_minus_head = free_q - CountW'(head_amt);
  assign out_free        = !out_valid_q || !out_stall_i;

  // Status for the controller.
  always_comb begin
    status_o.is_signal  = (item_i.operation == OpSignal);
    status_o.amt_zero   = (amt == '0);
    status_o.fits       = (free_q >= CountW'(amt));
    status_o.queue_full = (total_q == TotalW'(QueueDepth));
    status_o.head_fits  = (total_q != '0) && (pops_q < PopW'(ResultLimit)) &&
                          (CountW'(head_amt) <= free_q);
    status_o.pend_valid = pend_valid_q;
    status_o.out_free   = out_free;
  end

  // Free count, queue pointers and the pending released waiter.
  always_comb begin
    free_d       = free_q;
    head_d       = head_q;
    tail_d       = tail_q;
    total_d      = total_q;
    pops_d       = pops_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    if (cfg_we_i) begin
      free_d = cfg_wdata_i;
    end else if (cmd_i.wait_grant) begin
      free_d = free_minus_amt;
    end else if (cmd_i.wait_queue) begin
      tail_d  = next_idx(tail_q);
      total_d = total_q + TotalW'(1);
    end else if (cmd_i.signal_add) begin
      free_d = sat_sum;
      pops_d = '0;
    end else if (cmd_i.pop) begin
      free_d           = free_minus_head;
      head_d           = next_idx(head_q);
      total_d          = total_q - TotalW'(1);
      pops_d           = pops_q + PopW'(1);
      pend_d.kind      = KindReleased;
      pend_d.client    = head_client;
      pend_d.units     = head_amt;
      pend_d.available = free_minus_head;
      pend_d.last      = 1'b0;
      pend_valid_d     = 1'b1;
    end else if (cmd_i.flush_pend) begin
      pend_valid_d = 1'b0;
    end
  end

  // Result selection into the output register.
  always_comb begin
    out_load = 1'b1;
    out_d    = out_q;
    if (cmd_i.reject) begin
      out_d = '{kind: KindRejected, client: item_i.requester, units: amt,
                available: free_q, last: 1'b1};
    end else if (cmd_i.wait_grant) begin
      out_d = '{kind: KindGranted, client: item_i.requester, units: amt,
                available: free_minus_amt, last: 1'b1};
    end else if (cmd_i.wait_queue) begin
      out_d = '{kind: KindQueued, client: item_i.requester, units: amt,
                available: free_q, last: 1'b1};
    end else if (cmd_i.no_release) begin
      out_d = '{kind: KindNoRelease, client: '0, units: sig_amt_q,
                available: free_q, last: 1'b1};
    end else if (cmd_i.flush_pend) begin
      out_d      = pend_q;
      out_d.last = 1'b1;
    end else if (cmd_i.pop && pend_valid_q) begin
      out_d = pend_q;
    end else begin
      out_load = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state and counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q       <= '0;
      free_q       <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      total_q      <= '0;
      pops_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        init_q <= cfg_wdata_i;
      end
      free_q       <= free_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      total_q      <= total_d;
      pops_q       <= pops_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers, the waiter store and its registered head entry.
  // A waiter pushed into an empty queue is forwarded straight to the head.
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    out_q  <= out_d;
    if (cmd_i.signal_add) begin
      sig_amt_q <= amt;
    end
    if (cmd_i.wait_queue) begin
      q_client[tail_q] <= item_i.requester;
      q_amount[tail_q] <= amt;
    end
    if (cmd_i.wait_queue && (tail_q == head_d)) begin
      head_client_q <= item_i.requester;
      head_amt_q    <= amt;
    end else begin
      head_client_q <= q_client[head_d];
      head_amt_q    <= q_amount[head_d];
    end
  end

  assign cfg_rdata_o = init_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The waiter count never exceeds the queue depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TotalW'(QueueDepth))
    else $error("waiter count above queue depth");

  // A waiter is popped only from a non-empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> total_q != '0)
    else $error("pop from empty queue");

  // A waiter is pushed only into a queue with room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wait_queue |-> total_q < TotalW'(QueueDepth))
    else $error("push into full queue");

  // Head, tail and count stay consistent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((32'(head_q) + 32'(total_q)) % QueueDepth) == 32'(tail_q))
    else $error("queue pointers out of step with count");

  // A result is written only into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overwritten");

endmodule

// File: sv/fcs_ctrl.sv
module fcs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  fcs_pkg::status_t status_i,
  output fcs_pkg::cmd_t    cmd_o
);
  import fcs_pkg::*;

  typedef enum logic {
    StIdle,
    StRelease
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  // Transactions are taken only in idle with room in the output register.
  assign in_stall_o = !((state_q == StIdle) && status_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // Command decode and next state.
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (status_i.amt_zero) begin
            cmd_o.reject = 1'b1;
          end else if (status_i.is_signal) begin
            cmd_o.signal_add = 1'b1;
            state_d          = StRelease;
          end else if (status_i.fits) begin
            cmd_o.wait_grant = 1'b1;
          end else if (status_i.queue_full) begin
            cmd_o.reject = 1'b1;
          end else begin
            cmd_o.wait_queue = 1'b1;
          end
        end
      end
      StRelease: begin
        if (status_i.head_fits) begin
          if (!status_i.pend_valid || status_i.out_free) begin
            cmd_o.pop = 1'b1;
          end
        end else if (status_i.out_free) begin
          if (status_i.pend_valid) begin
            cmd_o.flush_pend = 1'b1;
          end else begin
            cmd_o.no_release = 1'b1;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Release commands appear only while releasing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.pop || cmd_o.flush_pend || cmd_o.no_release) |-> state_q == StRelease)
    else $error("release command outside release phase");

  // A signal transaction always moves to the release phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.signal_add |=> state_q == StRelease)
    else $error("signal did not start release phase");

  // At most one command is issued per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("conflicting commands");

endmodule

// File: dv/fifo_counting_semaphore_test.sv
module fifo_counting_semaphore_test;
  import fcs_pkg::*;

  localparam int unsigned WatchdogLimit  = 3000;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned SettleCycles   = 24;
  localparam int unsigned ReportLimit    = 10;
  localparam int unsigned RandomPhases   = 6;
  localparam int unsigned PhaseRequests  = 67;
  localparam int unsigned LongHoldAfter  = 140;

  localparam logic [AddrW-1:0] InitialCountAddr = AddrW'(4 * RegInitialCount);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall_o;
  in_item_t in_data = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  out_item_t out_data_o;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [CountW-1:0] pwdata = '0;
  logic [CountW-1:0] prdata;
  logic pready;

  // Semaphore state as the checker sees it.
  logic [CountW-1:0] model_free = '0;
  logic [ClientW-1:0] waiter_client[$];
  logic [AmountW-1:0] waiter_units[$];

  // Requests still to be offered, and replies the block still owes.
  in_item_t client_requests[$];
  out_item_t semaphore_replies[$];
  out_item_t oldest_reply;

  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  int unsigned send_gap = 0;
  int unsigned send_burst = 0;
  int unsigned stall_hold = 0;
  int unsigned stall_quiet = 0;
  int unsigned quiet_cycles = 0;
  bit long_hold_done = 1'b0;

  fifo_counting_semaphore dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // True when the head waiter can be released within this signal's budget.
  function automatic bit head_waiter_fits(input int unsigned released);
    return waiter_units.size() != 0 && released < ResultLimit &&
           waiter_units[0] <= model_free;
  endfunction

  // Work out the replies that one accepted transaction causes.
  function automatic void apply_semaphore_op(input in_item_t txn);
    logic [AmountW-1:0] amt;
    logic [CountW:0] total;
    out_item_t reply;
    int unsigned released;
    bit more;
    amt = txn.amount & AmountMask;
    reply.client = txn.requester;
    reply.units = amt;
    reply.last = 1'b1;
    if (amt == '0) begin
      reply.kind = KindRejected;
    end else if (txn.operation == OpWait) begin
      if (model_free >= amt) begin
        model_free = model_free - amt;
        reply.kind = KindGranted;
      end else if (waiter_client.size() >= QueueDepth) begin
        reply.kind = KindRejected;
      end else begin
        waiter_client.push_back(txn.requester);
        waiter_units.push_back(amt);
        reply.kind = KindQueued;
      end
    end else begin
      // Add the units with saturation, then release from the head.
      total = {1'b0, model_free} + amt;
      model_free = total[CountW] ? '1 : total[CountW-1:0];
      released = 0;
      more = head_waiter_fits(released);
      while (more) begin
        reply.kind = KindReleased;
        reply.client = waiter_client.pop_front();
        reply.units = waiter_units.pop_front();
        model_free = model_free - reply.units;
        reply.available = model_free;
        released++;
        more = head_waiter_fits(released);
        reply.last = !more;
        semaphore_replies.push_back(reply);
      end
      if (released != 0) begin
        return;
      end
      reply.kind = KindNoRelease;
      reply.client = '0;
    end
    reply.available = model_free;
    semaphore_replies.push_back(reply);
  endfunction

  function automatic in_item_t make_request(input logic op, input logic [ClientW-1:0] who,
                                            input logic [AmountW-1:0] amt);
    in_item_t txn;
    txn.operation = op;
    txn.requester = who;
    txn.amount = amt;
    return txn;
  endfunction

  // Mostly small amounts so that waiters pile up and get released.
  function automatic in_item_t random_request();
    in_item_t txn;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    txn.operation = ($urandom_range(0, 99) < 40) ? OpSignal : OpWait;
    txn.requester = ClientW'($urandom_range(0, 15));
    if (pick < 5) begin
      txn.amount = '0;
    end else if (pick < 65) begin
      txn.amount = AmountW'($urandom_range(1, 32));
    end else if (pick < 85) begin
      txn.amount = AmountW'($urandom_range(1, 1024));
    end else begin
      txn.amount = AmountW'($urandom);
    end
    return txn;
  endfunction

  // Sender gap: mostly short, a few long, with occasional back-to-back bursts.
  function automatic int unsigned next_send_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (send_burst != 0) begin
      send_burst--;
      return 0;
    end
    if (pick < 45) return 0;
    if (pick < 80) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    if (pick < 98) return $urandom_range(20, 60);
    send_burst = $urandom_range(20, 50);
    return 0;
  endfunction

  // Write the initial count, then read it back.
  task automatic write_initial_count(input logic [CountW-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= InitialCountAddr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    model_free = value;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== value) begin
      mismatch_count++;
      if (mismatch_count <= ReportLimit) begin
        $display("initial_count readback: expected %0h, got %0h", value, prdata);
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold off until every request has gone in and every reply has come back.
  task automatic wait_until_idle();
    while (client_requests.size() != 0 || in_valid || semaphore_replies.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Driver: offers queued requests and predicts each accepted transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        apply_semaphore_op(in_data);
      end
      if (!in_valid || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (client_requests.size() != 0) begin
          in_data <= client_requests.pop_front();
          in_valid <= 1'b1;
          send_gap = next_send_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random holds, quiet stretches, and one long hold-off.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (stall_hold != 0) begin
      stall_hold--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && results_seen >= LongHoldAfter) begin
      long_hold_done = 1'b1;
      stall_hold = LongHoldCycles;
      out_stall <= 1'b1;
    end else if (stall_quiet != 0) begin
      stall_quiet--;
      out_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:69]: begin
          out_stall <= 1'b0;
        end
        [70:96]: begin
          stall_hold = $urandom_range(0, 3);
          out_stall <= 1'b1;
        end
        [97:98]: begin
          stall_hold = $urandom_range(10, 40);
          out_stall <= 1'b1;
        end
        default: begin
          stall_quiet = $urandom_range(30, 80);
          out_stall <= 1'b0;
        end
      endcase
    end
  end

  // Monitor: every accepted reply must match the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      results_seen++;
      if (semaphore_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit) begin
          $display("unexpected reply: kind %0d client %0d units %0d available %0h last %0d",
                   out_data_o.kind, out_data_o.client, out_data_o.units,
                   out_data_o.available, out_data_o.last);
        end
      end else begin
        oldest_reply = semaphore_replies.pop_front();
        if (out_data_o.kind !== oldest_reply.kind ||
            out_data_o.client !== oldest_reply.client ||
            out_data_o.units !== oldest_reply.units ||
            out_data_o.available !== oldest_reply.available ||
            out_data_o.last !== oldest_reply.last) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit) begin
            $display("reply mismatch: expected kind %0d client %0d units %0d available %0h last %0d",
                     oldest_reply.kind, oldest_reply.client, oldest_reply.units,
                     oldest_reply.available, oldest_reply.last);
            $display("                got      kind %0d client %0d units %0d available %0h last %0d",
                     out_data_o.kind, out_data_o.client, out_data_o.units,
                     out_data_o.available, out_data_o.last);
          end
        end
      end
    end
  end

  // Watchdog: ends the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall) ||
        (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Test sequence.
  initial begin
    logic [CountW-1:0] start_counts[RandomPhases];
    int unsigned i;
    int unsigned p;
    start_counts[0] = '0;
    start_counts[1] = '1;
    start_counts[2] = 32'd12;
    start_counts[3] = $urandom;
    start_counts[4] = 32'd300;
    start_counts[5] = 32'd1;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero amounts, grants past a queued waiter, release and no release.
    write_initial_count(32'd5);
    @(negedge clk_i);
    client_requests.push_back(make_request(OpWait, 4'd0, 16'd0));
    client_requests.push_back(make_request(OpSignal, 4'd3, 16'd0));
    client_requests.push_back(make_request(OpWait, 4'd15, 16'd3));
    client_requests.push_back(make_request(OpWait, 4'd1, 16'hFFFF));
    client_requests.push_back(make_request(OpWait, 4'd2, 16'd1));
    client_requests.push_back(make_request(OpSignal, 4'd15, 16'hFFFF));
    client_requests.push_back(make_request(OpSignal, 4'd0, 16'd1));
    // Fill the queue, get rejected when full, grant a fitting wait anyway,
    // then release the whole queue with one signal.
    for (i = 0; i < QueueDepth; i++) begin
      client_requests.push_back(make_request(OpWait, ClientW'(i), AmountW'(100 + i)));
    end
    client_requests.push_back(make_request(OpWait, 4'd5, 16'd500));
    client_requests.push_back(make_request(OpWait, 4'd6, 16'd2));
    client_requests.push_back(make_request(OpSignal, 4'd0, 16'hFFFF));
    wait_until_idle();

    // Saturation of the free count at its top.
    write_initial_count('1);
    @(negedge clk_i);
    client_requests.push_back(make_request(OpSignal, 4'd8, 16'h8000));
    client_requests.push_back(make_request(OpWait, 4'd9, 16'hFFFF));
    wait_until_idle();

    // Reloading the count keeps a queued waiter until the next signal.
    write_initial_count('0);
    @(negedge clk_i);
    client_requests.push_back(make_request(OpWait, 4'd4, 16'd10));
    wait_until_idle();
    write_initial_count(32'd100);
    @(negedge clk_i);
    client_requests.push_back(make_request(OpSignal, 4'd0, 16'd1));
    wait_until_idle();

    // Random traffic over several starting counts.
    for (p = 0; p < RandomPhases; p++) begin
      write_initial_count(start_counts[p]);
      @(negedge clk_i);
      for (i = 0; i < PhaseRequests; i++) begin
        client_requests.push_back(random_request());
      end
      wait_until_idle();
    end

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/fcs_pkg.sv
sv/fcs_datapath.sv
sv/fcs_ctrl.sv
sv/fifo_counting_semaphore.sv
dv/fifo_counting_semaphore_test.sv
